// File: sv/hmtri_pkg.sv
// Shared types, constants and codes for the heightmap triangle interpolator.
`default_nettype none

package hmtri_pkg;

  // Default grid bounds for the height store.
  localparam int MaxColumnsDef = 64;
  localparam int MaxRowsDef    = 64;

  // Field widths.
  localparam int HeightW = 16;
  localparam int PointW  = 28;
  localparam int CellW   = 6;
  localparam int GridW   = 7;
  localparam int ShiftW  = 4;
  localparam int ShW     = 5;   // unit_shift + 8, up to 23
  localparam int FracW   = 24;  // holds one cell, up to 2^23
  localparam int DiffW   = HeightW + 1;
  localparam int ProdW   = DiffW + FracW + 1;
  localparam int AccW    = 44;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_COLUMNS   = 2'd0,
    CFG_GRID_ROWS      = 2'd1,
    CFG_OUTSIDE_HEIGHT = 2'd2,
    CFG_UNIT_SHIFT     = 2'd3
  } cfg_idx_e;

  localparam logic [GridW-1:0]          GridColumnsRst   = 7'd64;
  localparam logic [GridW-1:0]          GridRowsRst      = 7'd64;
  localparam logic signed [HeightW-1:0] OutsideHeightRst = -16'sd800;
  localparam logic [ShiftW-1:0]         UnitShiftRst     = 4'd8;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                       opcode;
    logic [CellW-1:0]           cell_x;
    logic [CellW-1:0]           cell_y;
    logic signed [HeightW-1:0]  new_height;
    logic signed [PointW-1:0]   point_x;
    logic signed [PointW-1:0]   point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [HeightW-1:0]  point_height;
    logic                       upper_triangle;
  } out_item_t;

  typedef enum logic [3:0] {
    SEQ_IDLE    = 4'd0,
    SEQ_RD_BASE = 4'd1,
    SEQ_RD_C1   = 4'd2,
    SEQ_RD_C2   = 4'd3,
    SEQ_MUL1    = 4'd4,
    SEQ_MUL2    = 4'd5,
    SEQ_ACC     = 4'd6,
    SEQ_RND     = 4'd7,
    SEQ_OUT     = 4'd8,
    SEQ_WRES    = 4'd9
  } seq_state_e;

  typedef enum logic [1:0] {
    CORNER_BASE = 2'd0,
    CORNER_C1   = 2'd1,
    CORNER_C2   = 2'd2
  } corner_e;

  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_BASE = 2'd1,
    CAP_C1   = 2'd2,
    CAP_C2   = 2'd3
  } cap_e;

  typedef enum logic [2:0] {
    MAC_IDLE = 3'd0,
    MAC_MUL  = 3'd1,
    MAC_LOAD = 3'd2,
    MAC_ADD  = 3'd3,
    MAC_RND  = 3'd4
  } mac_op_e;

  typedef struct packed {
    logic    in_ready;
    corner_e rd_corner;
    cap_e    cap;
    mac_op_e mac_op;
    logic    out_load;
    logic    out_zero;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// File: sv/hmtri_store.sv
// Height store: one write port and one registered read port.
`default_nettype none

module hmtri_store #(
  parameter int Depth = hmtri_pkg::MaxColumnsDef * hmtri_pkg::MaxRowsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [AddrW-1:0]                   waddr_i,
  input  wire logic signed [hmtri_pkg::HeightW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]                   raddr_i,
  output logic signed [hmtri_pkg::HeightW-1:0]      rdata_o
);

  logic signed [hmtri_pkg::HeightW-1:0] mem_q [Depth];
  logic signed [hmtri_pkg::HeightW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/hmtri_mac.sv
// Shared multiply-accumulate unit used for every product and sum of a query.
`default_nettype none

module hmtri_mac (
  input  wire logic                                 clk_i,
  input  wire hmtri_pkg::mac_op_e                   op_i,
  input  wire logic signed [hmtri_pkg::DiffW-1:0]   diff_i,
  input  wire logic [hmtri_pkg::FracW-1:0]          weight_i,
  input  wire logic signed [hmtri_pkg::HeightW-1:0] base_i,
  input  wire logic [hmtri_pkg::ShW-1:0]            sh_i,
  output logic signed [hmtri_pkg::AccW-1:0]         acc_o
);

  logic signed [hmtri_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [hmtri_pkg::AccW-1:0]  acc_q;
  logic signed [hmtri_pkg::AccW-1:0]  base_sh;
  logic signed [hmtri_pkg::AccW-1:0]  half;

  always_comb begin
    prod_d  = hmtri_pkg::ProdW'(diff_i * $signed({1'b0, weight_i}));
    base_sh = hmtri_pkg::AccW'(base_i) <<< sh_i;
    half    = $signed(hmtri_pkg::AccW'(1) << (sh_i - hmtri_pkg::ShW'(1)));
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      hmtri_pkg::MAC_MUL: begin
        prod_q <= prod_d;
      end
      hmtri_pkg::MAC_LOAD: begin
        acc_q  <= base_sh + hmtri_pkg::AccW'(prod_q);
        prod_q <= prod_d;
      end
      hmtri_pkg::MAC_ADD: begin
        acc_q <= acc_q + hmtri_pkg::AccW'(prod_q);
      end
      hmtri_pkg::MAC_RND: begin
        acc_q <= acc_q + half;
      end
      default: begin
      end
    endcase
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: sv/hmtri_seq.sv
// Sequencer that steps one query through corner reads, products and rounding.
`default_nettype none

module hmtri_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_query_i,
  input  wire logic          slot_free_i,
  output hmtri_pkg::seq_ctrl_t ctrl_o
);

  hmtri_pkg::seq_state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmtri_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    ctrl_o.in_ready  = 1'b0;
    ctrl_o.rd_corner = hmtri_pkg::CORNER_BASE;
    ctrl_o.cap       = hmtri_pkg::CAP_NONE;
    ctrl_o.mac_op    = hmtri_pkg::MAC_IDLE;
    ctrl_o.out_load  = 1'b0;
    ctrl_o.out_zero  = 1'b0;
    case (state_q)
      hmtri_pkg::SEQ_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = in_query_i ? hmtri_pkg::SEQ_RD_BASE : hmtri_pkg::SEQ_WRES;
        end
      end
      hmtri_pkg::SEQ_RD_BASE: begin
        ctrl_o.rd_corner = hmtri_pkg::CORNER_BASE;
        state_d          = hmtri_pkg::SEQ_RD_C1;
      end
      // Read data is registered, so each corner is captured in the state after its read.
      hmtri_pkg::SEQ_RD_C1: begin
        ctrl_o.rd_corner = hmtri_pkg::CORNER_C1;
        ctrl_o.cap       = hmtri_pkg::CAP_BASE;
        state_d          = hmtri_pkg::SEQ_RD_C2;
      end
      hmtri_pkg::SEQ_RD_C2: begin
        ctrl_o.rd_corner = hmtri_pkg::CORNER_C2;
        ctrl_o.cap       = hmtri_pkg::CAP_C1;
        state_d          = hmtri_pkg::SEQ_MUL1;
      end
      hmtri_pkg::SEQ_MUL1: begin
        ctrl_o.cap    = hmtri_pkg::CAP_C2;
        ctrl_o.mac_op = hmtri_pkg::MAC_MUL;
        state_d       = hmtri_pkg::SEQ_MUL2;
      end
      hmtri_pkg::SEQ_MUL2: begin
        ctrl_o.mac_op = hmtri_pkg::MAC_LOAD;
        state_d       = hmtri_pkg::SEQ_ACC;
      end
      hmtri_pkg::SEQ_ACC: begin
        ctrl_o.mac_op = hmtri_pkg::MAC_ADD;
        state_d       = hmtri_pkg::SEQ_RND;
      end
      hmtri_pkg::SEQ_RND: begin
        ctrl_o.mac_op = hmtri_pkg::MAC_RND;
        state_d       = hmtri_pkg::SEQ_OUT;
      end
      hmtri_pkg::SEQ_OUT: begin
        if (slot_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = hmtri_pkg::SEQ_IDLE;
        end
      end
      hmtri_pkg::SEQ_WRES: begin
        if (slot_free_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_zero = 1'b1;
          state_d         = hmtri_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = hmtri_pkg::SEQ_IDLE;
      end
    endcase
  end

  a_query_starts_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && ctrl_o.in_ready && in_query_i |=> state_q == hmtri_pkg::SEQ_RD_BASE)
    else $error("query word did not start the corner reads");

  a_write_goes_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && ctrl_o.in_ready && !in_query_i |=> state_q == hmtri_pkg::SEQ_WRES)
    else $error("write word did not go to its result state");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> slot_free_i)
    else $error("result loaded over an untaken word");

endmodule

`default_nettype wire

// File: sv/heightmap_triangle_interpolator.sv
// Top level of the heightmap triangle interpolator.
//
// A write word stores one Q12.4 corner height and loads a zero result in its result
// state. A query word steps through its base, first and second corner reads, the
// two products, the accumulate and the rounding, and then loads its result. A new
// word is accepted only in idle, after the last result is loaded. The query time
// is set by the single read port of the height store (three corner reads, one per
// cycle, with registered data) and by the one shared multiply-accumulate unit that
// forms both weighted differences, adds them and rounds. A finished result waits
// in the output register while the next word is taken; a result that finds the
// output register still occupied holds the sequencer until it is free. The store
// has no reset; only written corners give meaningful heights, and corners outside
// the grid read the configured outside height.
`default_nettype none

module heightmap_triangle_interpolator #(
  parameter int MAX_COLUMNS = hmtri_pkg::MaxColumnsDef,
  parameter int MAX_ROWS    = hmtri_pkg::MaxRowsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire hmtri_pkg::in_item_t                    in_data_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output hmtri_pkg::out_item_t                        out_data_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [hmtri_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire logic [hmtri_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int Depth       = MAX_COLUMNS * MAX_ROWS;
  localparam int AddrW       = $clog2(Depth);
  localparam int MaxColsClip = (MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS;
  localparam int MaxRowsClip = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int PadW        = hmtri_pkg::PointW - hmtri_pkg::GridW;

  localparam logic signed [hmtri_pkg::AccW-1:0] SatMax = hmtri_pkg::AccW'(32767);
  localparam logic signed [hmtri_pkg::AccW-1:0] SatMin = hmtri_pkg::AccW'(-32768);

  // Configuration registers.
  logic [hmtri_pkg::GridW-1:0]          cols_q, rows_q;
  logic signed [hmtri_pkg::HeightW-1:0] outside_q;
  logic [hmtri_pkg::ShiftW-1:0]         shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= hmtri_pkg::GridColumnsRst;
      rows_q    <= hmtri_pkg::GridRowsRst;
      outside_q <= hmtri_pkg::OutsideHeightRst;
      shift_q   <= hmtri_pkg::UnitShiftRst;
    end else if (cfg_valid_i) begin
      case (hmtri_pkg::cfg_idx_e'(cfg_index_i))
        hmtri_pkg::CFG_GRID_COLUMNS:   cols_q    <= cfg_data_i[hmtri_pkg::GridW-1:0];
        hmtri_pkg::CFG_GRID_ROWS:      rows_q    <= cfg_data_i[hmtri_pkg::GridW-1:0];
        hmtri_pkg::CFG_OUTSIDE_HEIGHT: outside_q <= $signed(cfg_data_i);
        hmtri_pkg::CFG_UNIT_SHIFT:     shift_q   <= cfg_data_i[hmtri_pkg::ShiftW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [hmtri_pkg::GridW-1:0] eff_cols, eff_rows;

  assign eff_cols = (cols_q > hmtri_pkg::GridW'(MaxColsClip)) ?
                    hmtri_pkg::GridW'(MaxColsClip) : cols_q;
  assign eff_rows = (rows_q > hmtri_pkg::GridW'(MaxRowsClip)) ?
                    hmtri_pkg::GridW'(MaxRowsClip) : rows_q;

  // Sequencer.
  hmtri_pkg::seq_ctrl_t ctrl;
  logic                 in_query;
  logic                 in_acc;
  logic                 out_valid_q;
  hmtri_pkg::out_item_t out_data_q;
  logic                 slot_free;

  assign in_query  = (in_data_i.opcode == hmtri_pkg::OP_QUERY);
  assign in_acc    = in_valid_i && ctrl.in_ready;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = ctrl.in_ready;

  hmtri_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_query_i (in_query),
    .slot_free_i(slot_free),
    .ctrl_o     (ctrl)
  );

  // Write path: columns and rows of zero count as outside.
  logic             wr_ok;
  logic             store_we;
  logic [AddrW-1:0] waddr;

  assign wr_ok = (in_data_i.cell_x != '0) && (in_data_i.cell_y != '0) &&
                 ({1'b0, in_data_i.cell_x} < eff_cols) &&
                 ({1'b0, in_data_i.cell_y} < eff_rows);
  assign store_we = in_acc && !in_query && wr_ok;
  assign waddr = AddrW'(32'(in_data_i.cell_y) * 32'(MAX_COLUMNS) + 32'(in_data_i.cell_x));

  // Query setup: floor split of the point into cell and fractions.
  logic [hmtri_pkg::ShW-1:0]            sh, sh_q;
  logic [hmtri_pkg::FracW-1:0]          one, fx, fy;
  logic                                 upper;
  logic signed [hmtri_pkg::PointW-1:0]  ix_q, iy_q;
  logic [hmtri_pkg::FracW-1:0]          w1_q, w2_q;
  logic                                 upper_q;

  always_comb begin
    sh    = hmtri_pkg::ShW'(shift_q) + hmtri_pkg::ShW'(8);
    one   = hmtri_pkg::FracW'(1) << sh;
    fx    = in_data_i.point_x[hmtri_pkg::FracW-1:0] & (one - hmtri_pkg::FracW'(1));
    fy    = in_data_i.point_y[hmtri_pkg::FracW-1:0] & (one - hmtri_pkg::FracW'(1));
    upper = ({1'b0, fx} + {1'b0, fy}) > {1'b0, one};
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_query) begin
      sh_q    <= sh;
      ix_q    <= in_data_i.point_x >>> sh;
      iy_q    <= in_data_i.point_y >>> sh;
      upper_q <= upper;
      w1_q    <= upper ? one - fx : fx;
      w2_q    <= upper ? one - fy : fy;
    end
  end

  // Corner addressing. The far triangle is based on the opposite corner.
  logic signed [hmtri_pkg::PointW-1:0] ix1, iy1, cx_sel, cy_sel;
  logic                                sel_valid, rvalid_q;
  logic [AddrW-1:0]                    raddr;

  always_comb begin
    ix1 = ix_q + hmtri_pkg::PointW'(1);
    iy1 = iy_q + hmtri_pkg::PointW'(1);
    case (ctrl.rd_corner)
      hmtri_pkg::CORNER_C1: begin
        cx_sel = upper_q ? ix_q : ix1;
        cy_sel = upper_q ? iy1  : iy_q;
      end
      hmtri_pkg::CORNER_C2: begin
        cx_sel = upper_q ? ix1  : ix_q;
        cy_sel = upper_q ? iy_q : iy1;
      end
      default: begin
        cx_sel = upper_q ? ix1 : ix_q;
        cy_sel = upper_q ? iy1 : iy_q;
      end
    endcase
    sel_valid = (cx_sel >= hmtri_pkg::PointW'(1)) && (cy_sel >= hmtri_pkg::PointW'(1)) &&
                (cx_sel < $signed({PadW'(0), eff_cols})) &&
                (cy_sel < $signed({PadW'(0), eff_rows}));
    raddr = sel_valid ?
            AddrW'(32'(cy_sel[hmtri_pkg::GridW-1:0]) * 32'(MAX_COLUMNS) +
                   32'(cx_sel[hmtri_pkg::GridW-1:0])) : '0;
  end

  logic signed [hmtri_pkg::HeightW-1:0] rdata, corner_val;
  logic signed [hmtri_pkg::HeightW-1:0] base_q, c1_q, c2_q;

  hmtri_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(waddr),
    .wdata_i(in_data_i.new_height),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign corner_val = rvalid_q ? rdata : outside_q;

  always_ff @(posedge clk_i) begin
    rvalid_q <= sel_valid;
    case (ctrl.cap)
      hmtri_pkg::CAP_BASE: base_q <= corner_val;
      hmtri_pkg::CAP_C1:   c1_q   <= corner_val;
      hmtri_pkg::CAP_C2:   c2_q   <= corner_val;
      default: begin
      end
    endcase
  end

  // Shared arithmetic.
  logic signed [hmtri_pkg::DiffW-1:0] diff;
  logic [hmtri_pkg::FracW-1:0]        weight;
  logic signed [hmtri_pkg::AccW-1:0]  acc;

  always_comb begin
    if (ctrl.mac_op == hmtri_pkg::MAC_MUL) begin
      diff   = hmtri_pkg::DiffW'(c1_q) - hmtri_pkg::DiffW'(base_q);
      weight = w1_q;
    end else begin
      diff   = hmtri_pkg::DiffW'(c2_q) - hmtri_pkg::DiffW'(base_q);
      weight = w2_q;
    end
  end

  hmtri_mac u_mac (
    .clk_i   (clk_i),
    .op_i    (ctrl.mac_op),
    .diff_i  (diff),
    .weight_i(weight),
    .base_i  (base_q),
    .sh_i    (sh_q),
    .acc_o   (acc)
  );

  // The arithmetic shift of the rounded sum is the floor division by the cell size.
  logic signed [hmtri_pkg::AccW-1:0]    h_full;
  logic signed [hmtri_pkg::HeightW-1:0] h_sat;

  always_comb begin
    h_full = acc >>> sh_q;
    if (h_full > SatMax) begin
      h_sat = hmtri_pkg::HeightW'(SatMax);
    end else if (h_full < SatMin) begin
      h_sat = hmtri_pkg::HeightW'(SatMin);
    end else begin
      h_sat = h_full[hmtri_pkg::HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q.point_height   <= ctrl.out_zero ? '0 : h_sat;
      out_data_q.upper_triangle <= ctrl.out_zero ? 1'b0 : upper_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_store_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> in_valid_i && in_ready_o && !in_query)
    else $error("height store written without an accepted write word");

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the heightmap triangle interpolator.
`default_nettype none

module tb;

  class terrain_model;
    logic signed [hmtri_pkg::HeightW-1:0] heights[hmtri_pkg::MaxColumnsDef*hmtri_pkg::MaxRowsDef];
    int                                   cols;
    int                                   rows;
    int                                   shift;
    logic signed [hmtri_pkg::HeightW-1:0] outside_h;
    hmtri_pkg::out_item_t                 due[$];
    int                                   errors;

    function new();
      foreach (heights[i]) heights[i] = '0;
      cols      = int'(hmtri_pkg::GridColumnsRst);
      rows      = int'(hmtri_pkg::GridRowsRst);
      shift     = int'(hmtri_pkg::UnitShiftRst);
      outside_h = hmtri_pkg::OutsideHeightRst;
      errors    = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void set_reg(hmtri_pkg::cfg_idx_e idx, logic [hmtri_pkg::CfgDataW-1:0] d);
      case (idx)
        hmtri_pkg::CFG_GRID_COLUMNS:   cols = int'(d[hmtri_pkg::GridW-1:0]);
        hmtri_pkg::CFG_GRID_ROWS:      rows = int'(d[hmtri_pkg::GridW-1:0]);
        hmtri_pkg::CFG_OUTSIDE_HEIGHT: outside_h = d;
        hmtri_pkg::CFG_UNIT_SHIFT:     shift = int'(d[hmtri_pkg::ShiftW-1:0]);
        default: ;
      endcase
    endfunction

    function longint corner_height(longint x, longint y);
      int c_eff;
      int r_eff;
      c_eff = (cols < hmtri_pkg::MaxColumnsDef) ? cols : hmtri_pkg::MaxColumnsDef;
      r_eff = (rows < hmtri_pkg::MaxRowsDef) ? rows : hmtri_pkg::MaxRowsDef;
      if (x < 1 || y < 1 || x >= c_eff || y >= r_eff) return longint'(outside_h);
      return longint'(heights[int'(y) * hmtri_pkg::MaxColumnsDef + int'(x)]);
    endfunction

    // Updates the store for a write word and returns the result a word produces.
    function hmtri_pkg::out_item_t apply_word(hmtri_pkg::in_item_t w);
      hmtri_pkg::out_item_t res;
      int                   c_eff;
      int                   r_eff;
      int                   s;
      longint               one, px, py, fx, fy, ix, iy, b, num, h;
      res   = '0;
      c_eff = (cols < hmtri_pkg::MaxColumnsDef) ? cols : hmtri_pkg::MaxColumnsDef;
      r_eff = (rows < hmtri_pkg::MaxRowsDef) ? rows : hmtri_pkg::MaxRowsDef;
      if (w.opcode == hmtri_pkg::OP_WRITE) begin
        if (w.cell_x >= 1 && w.cell_y >= 1 && int'(w.cell_x) < c_eff &&
            int'(w.cell_y) < r_eff)
          heights[int'(w.cell_y) * hmtri_pkg::MaxColumnsDef + int'(w.cell_x)] = w.new_height;
        return res;
      end
      s   = shift + 8;
      one = longint'(1) << s;
      px  = longint'(w.point_x);
      py  = longint'(w.point_y);
      fx  = px & (one - 1);
      fy  = py & (one - 1);
      ix  = (px - fx) >>> s;
      iy  = (py - fy) >>> s;
      if (fx + fy <= one) begin
        b   = corner_height(ix, iy);
        num = b * one + (corner_height(ix + 1, iy) - b) * fx
                      + (corner_height(ix, iy + 1) - b) * fy;
        res.upper_triangle = 1'b0;
      end else begin
        b   = corner_height(ix + 1, iy + 1);
        num = b * one + (corner_height(ix, iy + 1) - b) * (one - fx)
                      + (corner_height(ix + 1, iy) - b) * (one - fy);
        res.upper_triangle = 1'b1;
      end
      // Arithmetic shift floors, so adding half first rounds ties upward.
      h = (num + one / 2) >>> s;
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      res.point_height = h[hmtri_pkg::HeightW-1:0];
      return res;
    endfunction

    function void note_word(hmtri_pkg::in_item_t w);
      due.push_back(apply_word(w));
    endfunction

    function void check_word(hmtri_pkg::out_item_t got);
      hmtri_pkg::out_item_t want;
      if (due.size() == 0) begin
        flag($sformatf("unexpected result: height %0d upper %0b",
                       $signed(got.point_height), got.upper_triangle));
        return;
      end
      want = due.pop_front();
      if (got.point_height !== want.point_height)
        flag($sformatf("point_height: expected %0d, got %0d",
                       $signed(want.point_height), $signed(got.point_height)));
      if (got.upper_triangle !== want.upper_triangle)
        flag($sformatf("upper_triangle: expected %0b, got %0b",
                       want.upper_triangle, got.upper_triangle));
    endfunction
  endclass

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  hmtri_pkg::in_item_t                 in_data_i   = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  hmtri_pkg::out_item_t                out_data_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [hmtri_pkg::CfgIdxW-1:0]       cfg_index_i = '0;
  logic [hmtri_pkg::CfgDataW-1:0]      cfg_data_i  = '0;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  // Stimulus-side view of the grid, so queries never touch an unwritten corner.
  int gen_cols  = int'(hmtri_pkg::GridColumnsRst);
  int gen_rows  = int'(hmtri_pkg::GridRowsRst);
  int gen_shift = int'(hmtri_pkg::UnitShiftRst);
  bit loaded[hmtri_pkg::MaxColumnsDef*hmtri_pkg::MaxRowsDef];

  terrain_model terrain = new();

  heightmap_triangle_interpolator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) terrain.check_word(out_data_o);
      if (cfg_valid_i && cfg_ready_o)
        terrain.set_reg(hmtri_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && in_ready_o) terrain.note_word(in_data_i);
    end
  end

  // Result side: random back-pressure, plus one long hold-off to fill the block.
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(hmtri_pkg::in_item_t w);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic hmtri_pkg::in_item_t noise_word();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(hmtri_pkg::in_item_t)-1:0];
  endfunction

  task automatic offer_write(int cx, int cy, logic [hmtri_pkg::HeightW-1:0] h);
    hmtri_pkg::in_item_t w;
    w            = noise_word();
    w.opcode     = hmtri_pkg::OP_WRITE;
    w.cell_x     = cx[hmtri_pkg::CellW-1:0];
    w.cell_y     = cy[hmtri_pkg::CellW-1:0];
    w.new_height = h;
    if (cx >= 1 && cy >= 1 && cx < gen_cols && cy < gen_rows)
      loaded[cy * hmtri_pkg::MaxColumnsDef + cx] = 1'b1;
    send_word(w);
  endtask

  function automatic bit corner_unloaded(longint x, longint y);
    if (x < 1 || y < 1 || x >= gen_cols || y >= gen_rows) return 1'b0;
    return !loaded[int'(y) * hmtri_pkg::MaxColumnsDef + int'(x)];
  endfunction

  // A query whose triangle holds an unwritten corner becomes a write of that corner.
  task automatic offer_query(logic signed [hmtri_pkg::PointW-1:0] px,
                             logic signed [hmtri_pkg::PointW-1:0] py);
    hmtri_pkg::in_item_t w;
    longint              one, fx, fy, ix, iy;
    longint              kx[3];
    longint              ky[3];
    one = longint'(1) << (gen_shift + 8);
    fx  = longint'(px) & (one - 1);
    fy  = longint'(py) & (one - 1);
    ix  = (longint'(px) - fx) >>> (gen_shift + 8);
    iy  = (longint'(py) - fy) >>> (gen_shift + 8);
    if (fx + fy <= one) begin
      kx = '{ix, ix + 1, ix};
      ky = '{iy, iy, iy + 1};
    end else begin
      kx = '{ix + 1, ix, ix + 1};
      ky = '{iy + 1, iy + 1, iy};
    end
    for (int i = 0; i < 3; i++) begin
      if (corner_unloaded(kx[i], ky[i])) begin
        offer_write(int'(kx[i]), int'(ky[i]), hmtri_pkg::HeightW'($urandom));
        return;
      end
    end
    w         = noise_word();
    w.opcode  = hmtri_pkg::OP_QUERY;
    w.point_x = px;
    w.point_y = py;
    send_word(w);
  endtask

  function automatic longint pick_frac(longint one);
    int r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 30) return one - 1;
    return longint'($urandom) & (one - 1);
  endfunction

  // Mostly cells near the loaded corner block, sometimes the far edge of the grid.
  function automatic longint pick_cell(int n);
    int w;
    w = (n - 1 < 8) ? n - 1 : 8;
    if (w < 1) w = 1;
    if ($urandom_range(99) < 80) return longint'($urandom_range(w + 1)) - 1;
    return longint'($urandom_range(n + 1, (n > 3) ? n - 3 : 0));
  endfunction

  task automatic pick_point(output logic signed [hmtri_pkg::PointW-1:0] px,
                            output logic signed [hmtri_pkg::PointW-1:0] py);
    longint one, fx, fy, wx, wy, lim;
    int     r;
    one = longint'(1) << (gen_shift + 8);
    lim = longint'(1) << (hmtri_pkg::PointW - 1);
    fx  = pick_frac(one);
    fy  = pick_frac(one);
    r   = $urandom_range(99);
    // Points on the diagonal still belong to the near triangle.
    if (r < 15 && fx > 0) fy = one - fx;
    else if (r < 22 && fx > 1) fy = one - fx + 1;
    wx = pick_cell(gen_cols) * one + fx;
    wy = pick_cell(gen_rows) * one + fy;
    px = (wx >= -lim && wx < lim) ? wx[hmtri_pkg::PointW-1:0] :
                                    hmtri_pkg::PointW'($urandom);
    py = (wy >= -lim && wy < lim) ? wy[hmtri_pkg::PointW-1:0] :
                                    hmtri_pkg::PointW'($urandom);
    if ($urandom_range(99) < 10) px = hmtri_pkg::PointW'($urandom);
    if ($urandom_range(99) < 10) py = hmtri_pkg::PointW'($urandom);
  endtask

  task automatic put_reg(hmtri_pkg::cfg_idx_e idx, logic [hmtri_pkg::CfgDataW-1:0] d);
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_config(int cols, int rows, int outside, int shift);
    put_reg(hmtri_pkg::CFG_GRID_COLUMNS, hmtri_pkg::CfgDataW'(cols));
    put_reg(hmtri_pkg::CFG_GRID_ROWS, hmtri_pkg::CfgDataW'(rows));
    put_reg(hmtri_pkg::CFG_OUTSIDE_HEIGHT, hmtri_pkg::CfgDataW'(outside));
    put_reg(hmtri_pkg::CFG_UNIT_SHIFT, hmtri_pkg::CfgDataW'(shift));
    cfg_valid_i <= 1'b0;
    gen_cols  = (cols < hmtri_pkg::MaxColumnsDef) ? cols : hmtri_pkg::MaxColumnsDef;
    gen_rows  = (rows < hmtri_pkg::MaxRowsDef) ? rows : hmtri_pkg::MaxRowsDef;
    gen_shift = shift;
  endtask

  task automatic preload_corners();
    int lim_x;
    int lim_y;
    lim_x = (gen_cols - 1 < 9) ? gen_cols - 1 : 9;
    lim_y = (gen_rows - 1 < 9) ? gen_rows - 1 : 9;
    for (int y = 1; y <= lim_y; y++)
      for (int x = 1; x <= lim_x; x++)
        if (!loaded[y * hmtri_pkg::MaxColumnsDef + x])
          offer_write(x, y, hmtri_pkg::HeightW'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (terrain.due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [hmtri_pkg::PointW-1:0] px, py;
    int set_cols[8];
    int set_rows[8];
    int set_outside[8];
    int set_shift[8];
    int cx, cy;
    set_cols    = '{64, 2, 64, 8, 127, 0, 13, 40};
    set_rows    = '{64, 2, 64, 5, 100, 1, 64, 3};
    set_outside = '{-800, -32768, 32767, 1234, -1, 500, -20000, 7};
    set_shift   = '{8, 4, 12, 0, 15, 6, 10, 5};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset configuration: one cell is 65536 units wide.
    offer_write(0, 5, 16'sd1000);
    offer_write(5, 0, 16'sd1000);
    offer_write(63, 63, 16'sh7fff);
    offer_write(1, 1, 16'sh8000);
    offer_write(2, 1, 16'sh7fff);
    offer_write(1, 2, 16'sd100);
    offer_write(2, 2, -16'sd5);
    offer_query(28'sd266, 28'sd276);
    offer_query(28'sd456, 28'sd406);
    offer_query(28'sd384, 28'sd384);
    offer_query(28'sd511, 28'sd511);
    offer_query(28'sd256, 28'sd256);
    offer_query(-28'sd1, -28'sd1);
    offer_query(28'sd100, 28'sd261);
    offer_query(28'sh8000000, 28'sh7ffffff);
    offer_query(28'sh7ffffff, 28'sh8000000);
    offer_query(28'sd16129, 28'sd16129);
    offer_write(1, 1, 16'sd4000);
    offer_query(28'sd300, 28'sd300);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      steady <= (p == 4);
      if (p == 2) hold_req <= 1'b1;
      write_config(set_cols[p], set_rows[p], set_outside[p], set_shift[p]);
      preload_corners();
      for (int k = 0; k < 132; k++) begin
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(99) < 70) begin
            cx = $urandom_range((gen_cols < 63) ? gen_cols : 63);
            cy = $urandom_range((gen_rows < 63) ? gen_rows : 63);
          end else begin
            cx = $urandom_range(63);
            cy = $urandom_range(63);
          end
          offer_write(cx, cy, hmtri_pkg::HeightW'($urandom));
        end else begin
          pick_point(px, py);
          offer_query(px, py);
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (terrain.due.size() != 0)
      terrain.flag($sformatf("%0d results never arrived", terrain.due.size()));
    if (terrain.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
